// ===== design/bsb_pkg.sv =====
package bsb_pkg;

  // Request payload field types
  typedef logic [2:0]  func_t;
  typedef logic [12:0] amount_t;
  typedef logic [5:0]  width_t;
  typedef logic [31:0] word_t;
  typedef logic [7:0]  byte_t;

  // Operation codes carried in func
  localparam func_t FUNC_INIT     = 3'd0;
  localparam func_t FUNC_SKIP     = 3'd1;
  localparam func_t FUNC_RD_BITS  = 3'd2;
  localparam func_t FUNC_RD_BYTES = 3'd3;
  localparam func_t FUNC_WR_BYTES = 3'd4;

  // Clamps on the width field
  localparam width_t MAX_BITS  = 6'd32;
  localparam width_t MAX_BYTES = 6'd4;

endpackage

// ===== design/bsb_if.sv =====
// Request channel: one operation per request
interface bsb_in_if import bsb_pkg::*; ();
  logic    valid;
  logic    ready;
  func_t   func;
  amount_t amount;
  width_t  width;
  word_t   data;

  modport source (output valid, func, amount, width, data, input ready);
  modport sink   (input valid, func, amount, width, data, output ready);
endinterface

// Result channel: one result per request
interface bsb_out_if import bsb_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t value;
  logic  at_end;
  logic  overflow;

  modport source (output valid, value, at_end, overflow, input ready);
  modport sink   (input valid, value, at_end, overflow, output ready);
endinterface

// ===== design/bsb_mem.sv =====
// Single-port byte store, registered read data
module bsb_mem #(
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== design/bsb_core.sv =====
// Cursor registers and the per-request sequencer around the byte store
module bsb_core import bsb_pkg::*; #(
  parameter int BUF_BYTES = 4096,
  localparam int AW = $clog2(BUF_BYTES),
  localparam int CW = $clog2(BUF_BYTES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clearing,
  bsb_in_if.sink        in_ch,
  bsb_out_if.source     out_ch,
  output logic          mem_en,
  output logic          mem_we,
  output logic [AW-1:0] mem_addr,
  output byte_t         mem_wdata,
  input  byte_t         mem_rdata
);

  // sum width for byte compares, bit-position width for bit compares
  localparam int SW = ((CW > 13) ? CW : 13) + 1;
  localparam int BW = CW + 4;
  localparam logic [SW-1:0] CAP   = SW'(BUF_BYTES);
  localparam logic [BW-1:0] CAP_B = BW'(BUF_BYTES * 8);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] rc;
  logic [2:0]    bo;
  logic [CW-1:0] wc;
  logic [AW-1:0] base;
  logic [2:0]    n_r;
  logic [2:0]    iss;
  logic [2:0]    rcv;
  logic          pend;
  logic [39:0]   acc;
  logic [2:0]    sh_r;
  logic [5:0]    mw_r;
  logic          ovf_r;
  logic [31:0]   wsh;
  logic [2:0]    wcnt;

  logic          accept;
  logic          out_free;
  width_t        wb;
  logic [2:0]    wy;
  logic [SW-1:0] pos;
  logic [SW-1:0] skip_end;
  logic [SW-1:0] rdb_end;
  logic [SW-1:0] wr_end;
  logic [BW-1:0] bit_end;
  logic [5:0]    bit_tot;
  logic [2:0]    bit_n;
  logic [5:0]    wr_sh;
  logic [39:0]   acc_sh;
  logic [32:0]   mask_w;
  word_t         val;

  function automatic logic [32:0] low_mask(input logic [5:0] w);
    low_mask = (33'd1 << w) - 33'd1;
  endfunction

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = (state == ST_IDLE) && !clearing;

  // clamped widths and candidate end positions
  assign wb       = (in_ch.width > MAX_BITS) ? MAX_BITS : in_ch.width;
  assign wy       = (in_ch.width > MAX_BYTES) ? 3'd4 : in_ch.width[2:0];
  assign pos      = SW'(rc) + SW'(bo != 3'd0);
  assign skip_end = pos + SW'(in_ch.amount);
  assign rdb_end  = pos + SW'(wy);
  assign wr_end   = SW'(wc) + SW'(wy);
  assign bit_end  = BW'({rc, bo}) + BW'(wb);
  assign bit_tot  = 6'(bo) + wb;
  assign bit_n    = 3'((bit_tot + 6'd7) >> 3);
  assign wr_sh    = {3'(3'd4 - wy), 3'b000};

  // result value: drop trailing bits of the last byte, keep the requested width
  assign acc_sh = acc >> sh_r;
  assign mask_w = low_mask(mw_r);
  assign val    = acc_sh[31:0] & mask_w[31:0];

  // memory port
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = base;
    mem_wdata = wsh[31:24];
    if (state == ST_READ && iss != n_r) begin
      mem_en = 1'b1;
    end else if (state == ST_WRITE) begin
      mem_en = 1'b1;
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rc           <= '0;
      bo           <= '0;
      wc           <= '0;
      pend         <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      // the done state reloads the register itself
      if (out_ch.valid && out_ch.ready && state != ST_DONE) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            // cursors move at once; nothing reads them until the result
            acc   <= '0;
            iss   <= '0;
            rcv   <= '0;
            case (in_ch.func)
              FUNC_INIT: begin
                mw_r  <= '0;
                sh_r  <= '0;
                state <= ST_DONE;
                if (SW'(in_ch.amount) > CAP) begin
                  ovf_r <= 1'b1;
                end else begin
                  ovf_r <= 1'b0;
                  rc    <= '0;
                  bo    <= '0;
                  wc    <= CW'(in_ch.amount);
                end
              end
              FUNC_SKIP: begin
                mw_r  <= '0;
                sh_r  <= '0;
                state <= ST_DONE;
                if (skip_end > CAP) begin
                  ovf_r <= 1'b1;
                end else begin
                  ovf_r <= 1'b0;
                  rc    <= CW'(skip_end);
                  bo    <= '0;
                end
              end
              FUNC_RD_BITS: begin
                if (wb != '0 && bit_end <= CAP_B) begin
                  ovf_r <= 1'b0;
                  base  <= AW'(rc);
                  n_r   <= bit_n;
                  sh_r  <= 3'(3'd0 - bit_tot[2:0]);
                  mw_r  <= wb;
                  rc    <= rc + CW'(bit_tot[5:3]);
                  bo    <= bit_tot[2:0];
                  state <= ST_READ;
                end else begin
                  // zero width does nothing, too wide is refused
                  ovf_r <= (wb != '0);
                  mw_r  <= '0;
                  sh_r  <= '0;
                  state <= ST_DONE;
                end
              end
              FUNC_RD_BYTES: begin
                if (wy != '0 && rdb_end <= CAP) begin
                  ovf_r <= 1'b0;
                  base  <= AW'(pos);
                  n_r   <= wy;
                  sh_r  <= '0;
                  mw_r  <= {wy, 3'b000};
                  rc    <= CW'(rdb_end);
                  bo    <= '0;
                  state <= ST_READ;
                end else begin
                  ovf_r <= (wy != '0);
                  mw_r  <= '0;
                  sh_r  <= '0;
                  state <= ST_DONE;
                end
              end
              FUNC_WR_BYTES: begin
                mw_r <= '0;
                sh_r <= '0;
                if (wy != '0 && wr_end <= CAP) begin
                  ovf_r <= 1'b0;
                  base  <= AW'(wc);
                  wsh   <= in_ch.data << wr_sh;
                  wcnt  <= wy;
                  wc    <= CW'(wr_end);
                  state <= ST_WRITE;
                end else begin
                  ovf_r <= (wy != '0);
                  state <= ST_DONE;
                end
              end
              default: begin
                ovf_r <= 1'b0;
                mw_r  <= '0;
                sh_r  <= '0;
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_READ: begin
          // one byte issued and one collected per cycle
          pend <= mem_en;
          if (mem_en) begin
            iss  <= iss + 3'd1;
            base <= base + AW'(1);
          end
          if (pend) begin
            acc <= {acc[31:0], mem_rdata};
            rcv <= rcv + 3'd1;
            if (rcv + 3'd1 == n_r) begin
              state <= ST_DONE;
            end
          end
        end
        ST_WRITE: begin
          wsh  <= {wsh[23:0], 8'h00};
          base <= base + AW'(1);
          wcnt <= wcnt - 3'd1;
          if (wcnt == 3'd1) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_ch.valid    <= 1'b1;
            out_ch.value    <= val;
            out_ch.at_end   <= (pos >= SW'(wc));
            out_ch.overflow <= ovf_r;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // no request taken while the store is being cleared
  assert property (@(posedge clk) disable iff (rst) clearing |-> !in_ch.ready)
    else $error("request accepted during clearing pass");

  // store writes only come from a write request
  assert property (@(posedge clk) disable iff (rst) mem_we |-> (state == ST_WRITE))
    else $error("store written outside write sequence");

  // cursors never pass capacity
  assert property (@(posedge clk) disable iff (rst) (SW'(wc) <= CAP) && (pos <= CAP))
    else $error("cursor beyond capacity");

  // a new result only comes out of the done state
  assert property (@(posedge clk) disable iff (rst)
                   $rose(out_ch.valid) |-> $past(state == ST_DONE))
    else $error("result issued outside done state");

  // no more reads issued than bytes needed
  assert property (@(posedge clk) disable iff (rst) (state == ST_READ) |-> (iss <= n_r))
    else $error("read issue count overran");

endmodule

// ===== design/msb_first_bitstream_buffer.sv =====
// MSB-first bitstream buffer.
// in_ch carries one request per handshake (func, amount, width, data); out_ch
// returns exactly one result (value, at_end, overflow) per request, in order.
// Operations: init, skip, read up to 32 bits, read 1..4 bytes, write 1..4 bytes.
// The byte store sits in a single-port memory with registered read data,
// one byte touched per cycle, so timing follows the bytes an operation touches:
//   init, skip, zero width or refused: straight to the done state
//   read touching n bytes (n up to 5):  n byte reads issued and collected, then done
//   write of w bytes:                   w byte writes, then done
// Result is registered from the done state, after the last byte is collected or written.
// Requests are taken one at a time; a finished result sits in an output
// register, and while the receiver stalls the block can still take the next
// request, holding that one's result in its done state until the register frees.
// After reset the store is cleared by a pass over all BUF_BYTES bytes, one byte a
// cycle; ready stays low until it ends. Cursors reset to zero at once.
module msb_first_bitstream_buffer import bsb_pkg::*; #(
  parameter int BUF_BYTES = 4096
) (
  input  logic      clk,
  input  logic      rst,
  bsb_in_if.sink    in_ch,
  bsb_out_if.source out_ch
);

  localparam int AW = $clog2(BUF_BYTES);

  logic          clr_busy;
  logic [AW-1:0] clr_addr;
  logic          core_en;
  logic          core_we;
  logic [AW-1:0] core_addr;
  byte_t         core_wdata;
  logic          mem_en;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  byte_t         mem_wdata;
  byte_t         mem_rdata;

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(BUF_BYTES - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // store port: sweep owns it while clearing
  assign mem_en    = clr_busy || core_en;
  assign mem_we    = clr_busy || core_we;
  assign mem_addr  = clr_busy ? clr_addr : core_addr;
  assign mem_wdata = clr_busy ? 8'h00 : core_wdata;

  bsb_mem #(.DEPTH(BUF_BYTES)) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  bsb_core #(.BUF_BYTES(BUF_BYTES)) u_core (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clr_busy),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_en    (core_en),
    .mem_we    (core_we),
    .mem_addr  (core_addr),
    .mem_wdata (core_wdata),
    .mem_rdata (mem_rdata)
  );

endmodule
